>>> sv/cfs_pkg.sv
package cfs_pkg;

   localparam int BYTE_W         = 8;
   localparam int IN_DATA_FIELDS = 8;
   localparam int DATA_SEL_W     = $clog2(IN_DATA_FIELDS);
   localparam int ID_W           = 29;
   localparam int LEN_W          = 4;
   localparam int CRC_W          = 16;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h69;
   localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;

   // Bytes in front of the payload that the CRC covers: second sync,
   // four identifier bytes and the length byte.
   localparam int HEAD_BYTES = 6;
   // Bytes of the frame outside the CRC-covered body: first sync and two CRC bytes.
   localparam int WRAP_BYTES = 3;

   // CRC-16/CCITT-FALSE update by one byte, MSB first
   function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[CRC_W-1]) begin
            c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[CRC_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> sv/cfs_channels.sv
interface cfs_req_if;
   logic                                valid;
   logic                                ready;
   logic [cfs_pkg::ID_W-1:0]            can_identifier;
   logic                                is_extended;
   logic [cfs_pkg::LEN_W-1:0]           msg_length;
   logic [cfs_pkg::BYTE_W-1:0]          data_byte_0;
   logic [cfs_pkg::BYTE_W-1:0]          data_byte_1;
   logic [cfs_pkg::BYTE_W-1:0]          data_byte_2;
   logic [cfs_pkg::BYTE_W-1:0]          data_byte_3;
   logic [cfs_pkg::BYTE_W-1:0]          data_byte_4;
   logic [cfs_pkg::BYTE_W-1:0]          data_byte_5;
   logic [cfs_pkg::BYTE_W-1:0]          data_byte_6;
   logic [cfs_pkg::BYTE_W-1:0]          data_byte_7;

   modport source (output valid, can_identifier, is_extended, msg_length,
                   data_byte_0, data_byte_1, data_byte_2, data_byte_3,
                   data_byte_4, data_byte_5, data_byte_6, data_byte_7,
                   input ready);
   modport sink   (input valid, can_identifier, is_extended, msg_length,
                   data_byte_0, data_byte_1, data_byte_2, data_byte_3,
                   data_byte_4, data_byte_5, data_byte_6, data_byte_7,
                   output ready);
endinterface

interface cfs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cfs_pkg::BYTE_W-1:0] frame_byte;
   logic                       last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

>>> sv/can_frame_serial_framer_crc16_unit.sv
// CAN message to serial frame framer with CRC-16/CCITT-FALSE.
//
// req_chan takes one CAN message per request (identifier, extended flag,
// length code, eight payload bytes). rsp_chan returns the serial frame one
// byte per transfer: sync 0xAA 0x69, identifier little-endian (bit 31 set
// for extended), length, DATA_BYTES payload bytes zeroed past the length,
// then CRC high and low byte; last_byte marks the CRC low byte.
//
// The CRC runs through a pipeline of DATA_BYTES + 6 stages, one byte per
// stage, behind an input register. With an open receiver the first byte of
// a frame passes the input register, every CRC stage, the serializer's frame
// register and its output register. A frame is DATA_BYTES + 9 bytes, so the
// byte-wide result port sets the sustained rate of requests.
// Requests keep entering the pipeline while a frame is being sent.
//
// Reset empties every stage and the output register. When the receiver
// stalls, the output byte holds and each stage holds once the one after it
// is full; requests are then refused until room opens.
module can_frame_serial_framer_crc16_unit #(
   parameter int DATA_BYTES = 8
) (
   input  logic      clock,
   input  logic      reset,
   cfs_req_if.sink   req_chan,
   cfs_rsp_if.source rsp_chan
);

   localparam int BODY_BYTES = DATA_BYTES + cfs_pkg::HEAD_BYTES;
   localparam int BW         = cfs_pkg::BYTE_W;

   logic [BODY_BYTES*BW-1:0]  body_s  [BODY_BYTES+1];
   logic [cfs_pkg::CRC_W-1:0] crc_s   [BODY_BYTES+1];
   logic [BODY_BYTES:0]       valid_s;
   logic [BODY_BYTES:0]       ready_s;

   assign crc_s[0] = cfs_pkg::CRC_INIT;

   cfs_capture #(
      .DATA_BYTES (DATA_BYTES)
   ) u_capture (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .dn_valid (valid_s[0]),
      .dn_ready (ready_s[0]),
      .dn_body  (body_s[0])
   );

   for (genvar g = 0; g < BODY_BYTES; g++) begin : g_crc
      cfs_crc_stage #(
         .BODY_BYTES (BODY_BYTES),
         .BYTE_IDX   (g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (valid_s[g]),
         .up_ready (ready_s[g]),
         .up_body  (body_s[g]),
         .up_crc   (crc_s[g]),
         .dn_valid (valid_s[g+1]),
         .dn_ready (ready_s[g+1]),
         .dn_body  (body_s[g+1]),
         .dn_crc   (crc_s[g+1])
      );
   end

   cfs_serializer #(
      .BODY_BYTES (BODY_BYTES)
   ) u_serializer (
      .clock    (clock),
      .reset    (reset),
      .up_valid (valid_s[BODY_BYTES]),
      .up_ready (ready_s[BODY_BYTES]),
      .up_body  (body_s[BODY_BYTES]),
      .up_crc   (crc_s[BODY_BYTES]),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTH
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !valid_s[0] && !valid_s[BODY_BYTES])
      else $error("pipeline not empty after reset");

   a_crc_hold : assert property (@(posedge clock) disable iff (reset)
      valid_s[BODY_BYTES] && !ready_s[BODY_BYTES]
      |=> valid_s[BODY_BYTES] && $stable(crc_s[BODY_BYTES]))
      else $error("finished CRC lost while serializer busy");

   a_frame_boundary : assert property (@(posedge clock) disable iff (reset)
      valid_s[BODY_BYTES] && ready_s[BODY_BYTES] && rsp_chan.valid && !rsp_chan.ready
      |-> rsp_chan.last_byte)
      else $error("new frame loaded while previous frame still sending");
`endif

endmodule

>>> sv/cfs_capture.sv
module cfs_capture #(
   parameter int DATA_BYTES = 8
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   cfs_req_if.sink                                                  req_chan,
   output logic                                                     dn_valid,
   input  logic                                                     dn_ready,
   output logic [(DATA_BYTES+cfs_pkg::HEAD_BYTES)*cfs_pkg::BYTE_W-1:0] dn_body
);

   localparam int BODY_BYTES = DATA_BYTES + cfs_pkg::HEAD_BYTES;
   localparam int BW         = cfs_pkg::BYTE_W;

   logic [BW-1:0]            data_in [cfs_pkg::IN_DATA_FIELDS];
   logic [BODY_BYTES*BW-1:0] body_in;
   logic [BODY_BYTES*BW-1:0] body_ff;
   logic                     valid_in;
   logic                     valid_ff;
   logic                     take;

   assign data_in[0] = req_chan.data_byte_0;
   assign data_in[1] = req_chan.data_byte_1;
   assign data_in[2] = req_chan.data_byte_2;
   assign data_in[3] = req_chan.data_byte_3;
   assign data_in[4] = req_chan.data_byte_4;
   assign data_in[5] = req_chan.data_byte_5;
   assign data_in[6] = req_chan.data_byte_6;
   assign data_in[7] = req_chan.data_byte_7;

   assign req_chan.ready = !valid_ff || dn_ready;
   assign take           = req_chan.valid && req_chan.ready;

   // Lay out the CRC-covered body; zero payload past the length
   always_comb begin
      body_in = '0;
      body_in[BW-1:0]     = cfs_pkg::SYNC_SECOND;
      body_in[5*BW-1:BW]  = {req_chan.is_extended, 2'b00, req_chan.can_identifier};
      body_in[6*BW-1:5*BW] = {{(BW-cfs_pkg::LEN_W){1'b0}}, req_chan.msg_length};
      for (int i = 0; i < DATA_BYTES; i++) begin
         if ((i < cfs_pkg::IN_DATA_FIELDS) && (i < int'(req_chan.msg_length))) begin
            body_in[(i+cfs_pkg::HEAD_BYTES)*BW +: BW] = data_in[i[cfs_pkg::DATA_SEL_W-1:0]];
         end
      end
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (dn_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         body_ff <= body_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_body  = body_ff;

endmodule

>>> sv/cfs_crc_stage.sv
module cfs_crc_stage #(
   parameter int BODY_BYTES = 14,
   parameter int BYTE_IDX   = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  logic [BODY_BYTES*cfs_pkg::BYTE_W-1:0] up_body,
   input  logic [cfs_pkg::CRC_W-1:0]             up_crc,
   output logic                                  dn_valid,
   input  logic                                  dn_ready,
   output logic [BODY_BYTES*cfs_pkg::BYTE_W-1:0] dn_body,
   output logic [cfs_pkg::CRC_W-1:0]             dn_crc
);

   localparam int BW = cfs_pkg::BYTE_W;

   logic                     valid_in;
   logic                     valid_ff;
   logic [BODY_BYTES*BW-1:0] body_ff;
   logic [cfs_pkg::CRC_W-1:0] crc_in;
   logic [cfs_pkg::CRC_W-1:0] crc_ff;
   logic                     take;

   assign up_ready = !valid_ff || dn_ready;
   assign take     = up_valid && up_ready;
   assign crc_in   = cfs_pkg::crc_feed(up_crc, up_body[BYTE_IDX*BW +: BW]);

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (dn_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         body_ff <= up_body;
         crc_ff  <= crc_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_body  = body_ff;
   assign dn_crc   = crc_ff;

endmodule

>>> sv/cfs_serializer.sv
module cfs_serializer #(
   parameter int BODY_BYTES = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  logic [BODY_BYTES*cfs_pkg::BYTE_W-1:0] up_body,
   input  logic [cfs_pkg::CRC_W-1:0]             up_crc,
   cfs_rsp_if.source                             rsp_chan
);

   localparam int BW          = cfs_pkg::BYTE_W;
   localparam int FRAME_BYTES = BODY_BYTES + cfs_pkg::WRAP_BYTES;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   logic [BW-1:0]    frame_in [FRAME_BYTES];
   logic [BW-1:0]    frame_ff [FRAME_BYTES];
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] pos_ff;
   logic             busy_in;
   logic             busy_ff;
   logic             out_valid_in;
   logic             out_valid_ff;
   logic [BW-1:0]    out_byte_ff;
   logic             out_last_ff;
   logic             out_free;
   logic             emit;
   logic             at_last;
   logic             load;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign emit     = busy_ff && out_free;
   assign at_last  = (pos_ff == LAST_POS);
   // Take the next frame as the last byte of this one moves out
   assign up_ready = !busy_ff || (emit && at_last);
   assign load     = up_valid && up_ready;

   always_comb begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         frame_in[i] = frame_ff[i];
      end
      if (load) begin
         frame_in[0] = cfs_pkg::SYNC_FIRST;
         for (int i = 0; i < BODY_BYTES; i++) begin
            frame_in[i+1] = up_body[i*BW +: BW];
         end
         frame_in[BODY_BYTES+1] = up_crc[cfs_pkg::CRC_W-1 -: BW];
         frame_in[BODY_BYTES+2] = up_crc[BW-1:0];
      end else if (emit) begin
         // advance the shift line by one byte
         for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            frame_in[i] = frame_ff[i+1];
         end
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      busy_in = busy_ff;
      if (load) begin
         pos_in  = '0;
         busy_in = 1'b1;
      end else if (emit) begin
         if (at_last) begin
            pos_in  = '0;
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         frame_ff[i] <= frame_in[i];
      end
      if (emit) begin
         out_byte_ff <= frame_ff[0];
         out_last_ff <= at_last;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.frame_byte = out_byte_ff;
   assign rsp_chan.last_byte  = out_last_ff;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int FRAME_BYTES    = 17;
   localparam int ITEMS_PER_PASS = 40;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int CYCLE_LIMIT    = 200000;

   typedef struct packed {
      logic [cfs_pkg::ID_W-1:0]          can_identifier;
      logic                              is_extended;
      logic [cfs_pkg::LEN_W-1:0]         msg_length;
      logic [7:0][cfs_pkg::BYTE_W-1:0]   data;
   } can_msg_type;

   typedef struct packed {
      logic [cfs_pkg::BYTE_W-1:0] frame_byte;
      logic                       last_byte;
   } serial_byte_type;

   typedef struct {
      can_msg_type                     msg;
      bit                              typed;
      logic [31:0]                     id_word;
      logic [7:0][cfs_pkg::BYTE_W-1:0] payload;
   } msg_row_type;

   logic clock;
   logic reset;

   cfs_req_if req_chan ();
   cfs_rsp_if rsp_chan ();

   can_frame_serial_framer_crc16_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   serial_byte_type bytes_due [$];
   msg_row_type     msg_table [$];
   int unsigned     mismatches;
   int unsigned     cycle_count;
   int unsigned     send_idle_pct;
   int unsigned     recv_idle_pct;
   bit              long_hold_pending;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
                  bytes_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // bit-serial CRC-16/CCITT-FALSE, MSB first
   function automatic logic [cfs_pkg::CRC_W-1:0] crc_next(
         input logic [cfs_pkg::CRC_W-1:0]  crc,
         input logic [cfs_pkg::BYTE_W-1:0] b);
      logic fb;
      for (int i = cfs_pkg::BYTE_W - 1; i >= 0; i--) begin
         fb  = crc[cfs_pkg::CRC_W-1] ^ b[i];
         crc = {crc[cfs_pkg::CRC_W-2:0], 1'b0};
         if (fb) crc = crc ^ cfs_pkg::CRC_POLY;
      end
      return crc;
   endfunction

   function automatic logic [31:0] sent_identifier(input can_msg_type m);
      return {m.is_extended, 2'b00, m.can_identifier};
   endfunction

   function automatic logic [7:0][cfs_pkg::BYTE_W-1:0] padded_payload(
         input can_msg_type m);
      logic [7:0][cfs_pkg::BYTE_W-1:0] p;
      for (int i = 0; i < 8; i++) p[i] = (i < m.msg_length) ? m.data[i] : 8'h00;
      return p;
   endfunction

   // Build the whole serial frame and append it to the bytes due.
   task automatic queue_frame(input logic [31:0] id_word,
                              input logic [cfs_pkg::LEN_W-1:0] len,
                              input logic [7:0][cfs_pkg::BYTE_W-1:0] payload);
      logic [cfs_pkg::BYTE_W-1:0] body [FRAME_BYTES-2];
      logic [cfs_pkg::CRC_W-1:0]  crc;
      serial_byte_type            sb;
      body[0] = cfs_pkg::SYNC_FIRST;
      body[1] = cfs_pkg::SYNC_SECOND;
      for (int i = 0; i < 4; i++) body[2+i] = id_word[8*i +: 8];
      body[6] = {4'h0, len};
      for (int i = 0; i < 8; i++) body[7+i] = payload[i];
      crc = cfs_pkg::CRC_INIT;
      for (int i = 1; i < FRAME_BYTES - 2; i++) crc = crc_next(crc, body[i]);
      for (int i = 0; i < FRAME_BYTES - 2; i++) begin
         sb.frame_byte = body[i];
         sb.last_byte  = 1'b0;
         bytes_due.push_back(sb);
      end
      sb.frame_byte = crc[15:8];
      sb.last_byte  = 1'b0;
      bytes_due.push_back(sb);
      sb.frame_byte = crc[7:0];
      sb.last_byte  = 1'b1;
      bytes_due.push_back(sb);
   endtask

   task automatic offer(input can_msg_type m, input logic [31:0] id_word,
                        input logic [7:0][cfs_pkg::BYTE_W-1:0] payload);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.can_identifier <= m.can_identifier;
      req_chan.is_extended    <= m.is_extended;
      req_chan.msg_length     <= m.msg_length;
      req_chan.data_byte_0    <= m.data[0];
      req_chan.data_byte_1    <= m.data[1];
      req_chan.data_byte_2    <= m.data[2];
      req_chan.data_byte_3    <= m.data[3];
      req_chan.data_byte_4    <= m.data[4];
      req_chan.data_byte_5    <= m.data[5];
      req_chan.data_byte_6    <= m.data[6];
      req_chan.data_byte_7    <= m.data[7];
      do @(posedge clock); while (!req_chan.ready);
      queue_frame(id_word, m.msg_length, payload);
   endtask

   task automatic offer_predicted(input can_msg_type m);
      offer(m, sent_identifier(m), padded_payload(m));
   endtask

   // Hold the request channel low until every byte due has come out.
   task automatic drain_frames();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (bytes_due.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input logic [cfs_pkg::ID_W-1:0] id, input logic ext,
                          input logic [cfs_pkg::LEN_W-1:0] len, input logic [63:0] data,
                          input bit typed, input logic [31:0] id_word,
                          input logic [63:0] payload);
      msg_row_type r;
      r.msg.can_identifier = id;
      r.msg.is_extended    = ext;
      r.msg.msg_length     = len;
      r.msg.data           = data;
      r.typed              = typed;
      r.id_word            = id_word;
      r.payload            = payload;
      msg_table.push_back(r);
   endtask

   function automatic can_msg_type random_msg();
      can_msg_type m;
      int unsigned pick;
      logic [31:0] r32;
      pick = $urandom_range(99);
      if (pick < 45) begin
         r32              = $urandom_range(11'h7FF);
         m.can_identifier = r32[cfs_pkg::ID_W-1:0];
         m.is_extended    = ($urandom_range(9) == 0);
      end else if (pick < 90) begin
         r32              = $urandom;
         m.can_identifier = r32[cfs_pkg::ID_W-1:0];
         m.is_extended    = ($urandom_range(9) != 0);
      end else begin
         m.can_identifier = $urandom_range(1) ? '1 : '0;
         r32              = $urandom_range(1);
         m.is_extended    = r32[0];
      end
      r32          = ($urandom_range(3) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
      m.msg_length = r32[cfs_pkg::LEN_W-1:0];
      m.data       = {$urandom, $urandom};
      return m;
   endfunction

   // receiver: check every accepted byte, then pick ready for the next edge
   initial begin
      serial_byte_type want;
      int unsigned     hold_count;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h", rsp_chan.frame_byte));
            end else begin
               want = bytes_due.pop_front();
               if (rsp_chan.frame_byte !== want.frame_byte)
                  report_mismatch($sformatf("frame_byte %02h, want %02h",
                                            rsp_chan.frame_byte, want.frame_byte));
               if (rsp_chan.last_byte !== want.last_byte)
                  report_mismatch($sformatf("last_byte %0b, want %0b",
                                            rsp_chan.last_byte, want.last_byte));
            end
         end
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_chan.ready <= 1'b0;
            hold_count = 0;
            while (hold_count < LONG_HOLD) begin
               @(posedge clock);
               hold_count++;
            end
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.can_identifier <= '0;
      req_chan.is_extended    <= 1'b0;
      req_chan.msg_length     <= '0;
      req_chan.data_byte_0    <= '0;
      req_chan.data_byte_1    <= '0;
      req_chan.data_byte_2    <= '0;
      req_chan.data_byte_3    <= '0;
      req_chan.data_byte_4    <= '0;
      req_chan.data_byte_5    <= '0;
      req_chan.data_byte_6    <= '0;
      req_chan.data_byte_7    <= '0;
      mismatches        = 0;
      cycle_count       = 0;
      long_hold_pending = 1'b0;
      send_idle_pct     = 22;
      recv_idle_pct     = 62;

      // extremes, length zero and lengths past the payload size
      add_row(29'h0, 1'b0, 4'd0, 64'h0, 1, 32'h0000_0000, 64'h0);
      add_row(29'h7FF, 1'b0, 4'd8, '1, 1, 32'h0000_07FF, '1);
      add_row('1, 1'b1, 4'd15, '1, 1, 32'h9FFF_FFFF, '1);
      add_row('1, 1'b0, 4'd8, 64'h0, 1, 32'h1FFF_FFFF, 64'h0);
      add_row(29'h0, 1'b1, 4'd1, 64'hFFFF_FFFF_FFFF_FFA5, 1, 32'h8000_0000, 64'hA5);
      add_row(29'h123, 1'b0, 4'd0, '1, 1, 32'h0000_0123, 64'h0);
      add_row(29'h456, 1'b0, 4'd9, 64'h8877_6655_4433_2211, 1, 32'h0000_0456,
              64'h8877_6655_4433_2211);
      add_row(29'h0ABC_DEF0, 1'b1, 4'd3, 64'h8877_6655_4433_2211, 1, 32'h8ABC_DEF0,
              64'h0000_0000_0033_2211);
      add_row(29'h1555_5555, 1'b1, 4'd2, 64'h5555_5555_5555_5555, 0, '0, '0);
      add_row(29'h0AAA_AAAA, 1'b0, 4'd4, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0, '0);
      add_row(29'h2AA, 1'b0, 4'd5, 64'h0123_4567_89AB_CDEF, 0, '0, '0);
      add_row(29'h555, 1'b1, 4'd6, 64'hFEDC_BA98_7654_3210, 0, '0, '0);
      add_row(29'h1F0F_0F0F, 1'b1, 4'd7, 64'h00FF_00FF_00FF_00FF, 0, '0, '0);
      add_row(29'h00F0_F0F0, 1'b0, 4'd10, 64'hFF00_FF00_FF00_FF00, 0, '0, '0);
      add_row(29'h1234_5678, 1'b1, 4'd12, 64'hC3C3_3C3C_5AA5_A55A, 0, '0, '0);
      add_row(29'h7FE, 1'b0, 4'd14, 64'h8000_0000_0000_0001, 0, '0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (msg_table[i]) begin
         if (msg_table[i].typed)
            offer(msg_table[i].msg, msg_table[i].id_word, msg_table[i].payload);
         else
            offer_predicted(msg_table[i].msg);
      end

      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin
               send_idle_pct = 22;
               recv_idle_pct = 62;
            end
            1: begin
               drain_frames();
               send_idle_pct     = 62;
               recv_idle_pct     = 22;
               // stall the receiver long enough to back the pipeline up
               long_hold_pending = 1'b1;
            end
            default: begin
               drain_frames();
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PASS; n++) offer_predicted(random_msg());
      end

      drain_frames();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
